### design/esd_pkg.sv
// types, constants and character helpers for the escape sequence decoder
`timescale 1ns / 1ps
package esd_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [3:0] DIGIT_MASK   = 4'hf;
  localparam logic [7:0] LETTER_SHIFT = 8'd7;
  localparam logic [1:0] OCT_DIGITS   = 2'd3;
  localparam logic [1:0] HEX_DIGITS   = 2'd2;
  localparam int         MAX_RES      = 2;
  localparam int         QDEPTH       = 4;
  localparam int         QAW          = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_ESC_X  = 2'd2,
    MODE_DIGITS = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  acc;
    logic [1:0]  left;
    logic        hex;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
  } result_t;

  localparam dec_state_t STATE_RESET = '{mode: MODE_NORMAL, acc: 8'd0, left: 2'd0, hex: 1'b0};

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex_letter(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h66);
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] t;
    t = is_hex_letter(c) ? (c - LETTER_SHIFT) : c;
    return t[3:0] & DIGIT_MASK;
  endfunction

endpackage

### design/esd_if.sv
// item channel interfaces for the escape sequence decoder
`timescale 1ns / 1ps
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_marker;

  modport source (output valid, output in_char, output end_marker, input ready);
  modport sink   (input valid, input in_char, input end_marker, output ready);
endinterface

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;

  modport source (output valid, output out_byte, output byte_valid, output string_done,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input string_done,
                  output ready);
endinterface

### design/esd_decode.sv
// per-character escape decode: next state and up to two result items
`timescale 1ns / 1ps
module esd_decode (
  input  esd_pkg::dec_state_t st,
  input  logic [7:0]          ch,
  input  logic                end_marker,
  output esd_pkg::dec_state_t st_nxt,
  output logic [1:0]          res_cnt,
  output esd_pkg::result_t    res0,
  output esd_pkg::result_t    res1
);
  import esd_pkg::*;

  logic [7:0] c;
  logic       dig;
  logic       hexl;
  logic [3:0] dv;
  logic [7:0] acc_step;
  logic       do_normal;
  result_t    r [MAX_RES];
  logic [1:0] n;

  assign c    = to_lower(ch);
  assign dig  = is_dec(c);
  assign hexl = is_hex_letter(c);
  assign dv   = digit_value(c);

  always_comb begin
    if (st.hex) begin
      acc_step = {st.acc[3:0], dv};
    end else begin
      acc_step = {st.acc[4:0], 3'b000} + {4'd0, dv};
    end
  end

  always_comb begin
    st_nxt    = st;
    n         = 2'd0;
    do_normal = 1'b0;
    r[0]      = '0;
    r[1]      = '0;
    if (end_marker) begin
      if (st.mode == MODE_DIGITS) begin
        r[0] = '{out_byte: st.acc, byte_valid: 1'b1, string_done: 1'b0};
        r[1] = '{out_byte: 8'd0, byte_valid: 1'b0, string_done: 1'b1};
        n    = 2'd2;
      end else begin
        r[0] = '{out_byte: 8'd0, byte_valid: 1'b0, string_done: 1'b1};
        n    = 2'd1;
      end
      st_nxt = STATE_RESET;
    end else begin
      unique case (st.mode)
        MODE_ESC: begin
          if (c == CH_X) begin
            st_nxt.hex  = 1'b1;
            st_nxt.mode = MODE_ESC_X;
          end else if (dig) begin
            st_nxt.hex  = 1'b0;
            st_nxt.acc  = {4'd0, dv};
            st_nxt.left = OCT_DIGITS - 2'd1;
            st_nxt.mode = MODE_DIGITS;
          end else begin
            r[0]        = '{out_byte: c, byte_valid: 1'b1, string_done: 1'b0};
            n           = 2'd1;
            st_nxt.mode = MODE_NORMAL;
          end
        end
        MODE_ESC_X: begin
          if (dig || hexl) begin
            st_nxt.acc  = {4'd0, dv};
            st_nxt.left = HEX_DIGITS - 2'd1;
            st_nxt.mode = MODE_DIGITS;
          end else begin
            r[0]        = '{out_byte: c, byte_valid: 1'b1, string_done: 1'b0};
            n           = 2'd1;
            st_nxt.mode = MODE_NORMAL;
          end
        end
        MODE_DIGITS: begin
          if (dig || (st.hex && hexl)) begin
            if (st.left <= 2'd1) begin
              r[0]        = '{out_byte: acc_step, byte_valid: 1'b1, string_done: 1'b0};
              n           = 2'd1;
              st_nxt.mode = MODE_NORMAL;
              st_nxt.acc  = 8'd0;
              st_nxt.left = 2'd0;
            end else begin
              st_nxt.acc  = acc_step;
              st_nxt.left = st.left - 2'd1;
            end
          end else begin
            // flush the value, then treat the character as plain text
            r[0]        = '{out_byte: st.acc, byte_valid: 1'b1, string_done: 1'b0};
            n           = 2'd1;
            st_nxt.acc  = 8'd0;
            st_nxt.left = 2'd0;
            st_nxt.mode = MODE_NORMAL;
            do_normal   = 1'b1;
          end
        end
        default: begin
          do_normal = 1'b1;
        end
      endcase
      if (do_normal) begin
        if (ch == CH_BACKSLASH) begin
          st_nxt.mode = MODE_ESC;
        end else begin
          r[n[0]]     = '{out_byte: ch, byte_valid: 1'b1, string_done: 1'b0};
          n           = n + 2'd1;
          st_nxt.mode = MODE_NORMAL;
        end
      end
    end
  end

  assign res_cnt = n;
  assign res0    = r[0];
  assign res1    = r[1];

endmodule

### design/escape_sequence_decoder_core.sv
// top level of the escape sequence decoder: input register, decode, result queue
//
// channel | dir | payload                               | accepted when
// in_ch   | in  | in_char[7:0], end_marker              | valid && ready
// out_ch  | out | out_byte[7:0], byte_valid, string_done | valid && ready
//
// one input item per cycle unless decode waits; the input register feeds the decode stage
// an item gives zero, one or two results; a 4-entry queue sends one per cycle if out_ch is ready
// the decode stage waits while the queue holds more than two results
// synchronous active-low reset returns the escape state to normal copying and empties the queue
`timescale 1ns / 1ps
module escape_sequence_decoder_core (
  input  logic            clk,
  input  logic            rst_n,
  esd_in_if.sink          in_ch,
  esd_out_if.source       out_ch
);
  import esd_pkg::*;

  logic             hold_v_r;
  logic [7:0]       hold_char_r;
  logic             hold_end_r;
  dec_state_t       st_r;
  dec_state_t       st_nxt;
  logic [1:0]       res_cnt;
  result_t          res0;
  result_t          res1;
  result_t          q_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW:0]     cnt_r;
  logic             fire;
  logic             in_acc;
  logic             pop;
  logic [1:0]       push_n;
  logic [QAW-1:0]   wr_ptr1;

  esd_decode u_decode (
    .st         (st_r),
    .ch         (hold_char_r),
    .end_marker (hold_end_r),
    .st_nxt     (st_nxt),
    .res_cnt    (res_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  assign fire        = hold_v_r && (cnt_r <= (QAW + 1)'(QDEPTH - MAX_RES));
  assign in_ch.ready = !hold_v_r || fire;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;
  assign push_n      = fire ? res_cnt : 2'd0;
  assign wr_ptr1     = wr_ptr_r + QAW'(1);

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.out_byte    = q_r[rd_ptr_r].out_byte;
  assign out_ch.byte_valid  = q_r[rd_ptr_r].byte_valid;
  assign out_ch.string_done = q_r[rd_ptr_r].string_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      st_r     <= STATE_RESET;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_acc) begin
        hold_v_r <= 1'b1;
      end else if (fire) begin
        hold_v_r <= 1'b0;
      end
      if (fire) begin
        st_r <= st_nxt;
      end
      wr_ptr_r <= wr_ptr_r + QAW'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      cnt_r <= cnt_r + (QAW + 1)'(push_n) - (QAW + 1)'(pop);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_char_r <= in_ch.in_char;
      hold_end_r  <= in_ch.end_marker;
    end
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr1] <= res1;
    end
  end

endmodule
